@@ src/csp_pkg.sv @@
// Package for the color spec parser: character codes, parameter defaults,
// the result struct and the hex and component-reduction helpers.
// No dependencies; used by csp_step, csp_out_reg, color_spec_parser and the testbench.
`default_nettype none

package csp_pkg;

  localparam int MAX_HASH_DIGITS      = 12;
  localparam int MAX_COMPONENT_DIGITS = 4;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_R     = 8'h72;
  localparam logic [7:0] CHAR_G     = 8'h67;
  localparam logic [7:0] CHAR_B     = 8'h62;

  typedef struct packed {
    logic       ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } csp_result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nib;
  } csp_hex_t;

  // Decode one ASCII hex digit, either case.
  function automatic csp_hex_t hex_decode(input logic [7:0] ch);
    csp_hex_t h;
    h.is_hex = 1'b0;
    h.nib    = 4'h0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      h.is_hex = 1'b1;
      h.nib    = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      h.is_hex = 1'b1;
      h.nib    = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      h.is_hex = 1'b1;
      h.nib    = 4'(ch - 8'h37);
    end
    return h;
  endfunction

  // Reduce a component of n digits to 8 bits: one digit is replicated,
  // longer components keep their top byte.
  function automatic logic [7:0] reduce(input logic [15:0] val, input logic [2:0] n);
    logic [7:0] r;
    if (n <= 3'd1) begin
      r = {val[3:0], val[3:0]};
    end else if (n == 3'd2) begin
      r = val[7:0];
    end else if (n == 3'd3) begin
      r = val[11:4];
    end else begin
      r = val[15:8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/csp_in_reg.sv @@
// Input register of the color spec parser: holds one request character.
// Depends on nothing; the parse stage tells it when the character is taken.
`default_nettype none

module csp_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_stall,
  input  wire logic [7:0] character,
  input  wire logic       take,
  output logic            held_valid,
  output logic [7:0]      held_char
);

  // Stall only while a held character cannot move on.
  assign char_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!char_stall) begin
      held_valid <= char_valid;
    end
    if (char_valid && !char_stall) begin
      held_char <= character;
    end
  end

endmodule

`default_nettype wire

@@ src/csp_step.sv @@
// Parse stage of the color spec parser: the per-character state update and
// the result decode on the terminating zero. Uses csp_pkg.
`default_nettype none

module csp_step #(
  parameter int MAX_HASH_DIGITS      = csp_pkg::MAX_HASH_DIGITS,
  parameter int MAX_COMPONENT_DIGITS = csp_pkg::MAX_COMPONENT_DIGITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          held_valid,
  input  wire logic [7:0]    held_char,
  input  wire logic          out_free,
  output logic               take,
  output logic               res_load,
  output csp_pkg::csp_result_t res
);

  localparam int HW     = 4 * MAX_HASH_DIGITS;
  localparam int CW     = 4 * MAX_COMPONENT_DIGITS;
  localparam int DMAX   = (MAX_HASH_DIGITS > MAX_COMPONENT_DIGITS) ?
                          MAX_HASH_DIGITS : MAX_COMPONENT_DIGITS;
  localparam int DCW    = $clog2(DMAX + 1);

  typedef enum logic [2:0] {
    MODE_START,
    MODE_HASH,
    MODE_PREFIX,
    MODE_RGB,
    MODE_ERROR
  } mode_t;

  mode_t             mode, mode_next;
  logic [1:0]        prefix_pos, prefix_pos_next;
  logic [HW-1:0]     hash_nibbles, hash_nibbles_next;
  logic [DCW-1:0]    digit_count, digit_count_next;
  logic [1:0]        comp_index, comp_index_next;
  logic [CW-1:0]     comp_value, comp_value_next;
  logic [7:0]        held_red, held_red_next;
  logic [7:0]        held_green, held_green_next;

  csp_pkg::csp_hex_t hex;
  logic              is_nul;
  logic [7:0]        prefix_char;
  logic [47:0]       h48;
  logic [3:0]        dc4;
  logic [7:0]        comp_byte;

  assign is_nul    = (held_char == csp_pkg::CHAR_NUL);
  assign take      = held_valid && (!is_nul || out_free);
  assign res_load  = take && is_nul;
  assign hex       = csp_pkg::hex_decode(held_char);
  assign h48       = 48'(hash_nibbles);
  assign dc4       = 4'(digit_count);
  assign comp_byte = csp_pkg::reduce(16'(comp_value), 3'(digit_count));

  always_comb begin
    unique case (prefix_pos)
      2'd0:    prefix_char = csp_pkg::CHAR_R;
      2'd1:    prefix_char = csp_pkg::CHAR_G;
      2'd2:    prefix_char = csp_pkg::CHAR_B;
      default: prefix_char = csp_pkg::CHAR_COLON;
    endcase
  end

  // Result for the terminating zero, taken from the state before it.
  always_comb begin
    res = '0;
    if (mode == MODE_HASH) begin
      res.ok = 1'b1;
      unique case (dc4)
        4'd3: begin
          res.red   = {h48[11:8], h48[11:8]};
          res.green = {h48[7:4], h48[7:4]};
          res.blue  = {h48[3:0], h48[3:0]};
        end
        4'd6: begin
          res.red   = h48[23:16];
          res.green = h48[15:8];
          res.blue  = h48[7:0];
        end
        4'd9: begin
          res.red   = h48[35:28];
          res.green = h48[23:16];
          res.blue  = h48[11:4];
        end
        4'd12: begin
          res.red   = h48[47:40];
          res.green = h48[31:24];
          res.blue  = h48[15:8];
        end
        default: res = '0;
      endcase
    end else if (mode == MODE_RGB && comp_index == 2'd2 && digit_count != '0) begin
      res.ok    = 1'b1;
      res.red   = held_red;
      res.green = held_green;
      res.blue  = comp_byte;
    end
  end

  always_comb begin
    mode_next         = mode;
    prefix_pos_next   = prefix_pos;
    hash_nibbles_next = hash_nibbles;
    digit_count_next  = digit_count;
    comp_index_next   = comp_index;
    comp_value_next   = comp_value;
    held_red_next     = held_red;
    held_green_next   = held_green;
    if (is_nul) begin
      // Terminator: start a fresh spec.
      mode_next         = MODE_START;
      prefix_pos_next   = '0;
      hash_nibbles_next = '0;
      digit_count_next  = '0;
      comp_index_next   = '0;
      comp_value_next   = '0;
      held_red_next     = '0;
      held_green_next   = '0;
    end else begin
      unique case (mode)
        MODE_START: begin
          if (held_char == csp_pkg::CHAR_HASH) begin
            mode_next = MODE_HASH;
          end else if (held_char == csp_pkg::CHAR_R) begin
            mode_next       = MODE_PREFIX;
            prefix_pos_next = 2'd1;
          end else begin
            mode_next = MODE_ERROR;
          end
        end
        MODE_HASH: begin
          if (!hex.is_hex || digit_count >= DCW'(MAX_HASH_DIGITS)) begin
            mode_next = MODE_ERROR;
          end else begin
            hash_nibbles_next = HW'({hash_nibbles, hex.nib});
            digit_count_next  = digit_count + DCW'(1);
          end
        end
        MODE_PREFIX: begin
          if (held_char != prefix_char) begin
            mode_next = MODE_ERROR;
          end else if (prefix_pos == 2'd3) begin
            mode_next       = MODE_RGB;
            prefix_pos_next = '0;
          end else begin
            prefix_pos_next = prefix_pos + 2'd1;
          end
        end
        MODE_RGB: begin
          if (hex.is_hex) begin
            if (digit_count >= DCW'(MAX_COMPONENT_DIGITS)) begin
              mode_next = MODE_ERROR;
            end else begin
              comp_value_next  = CW'({comp_value, hex.nib});
              digit_count_next = digit_count + DCW'(1);
            end
          end else if (held_char == csp_pkg::CHAR_SLASH) begin
            if (digit_count == '0 || comp_index >= 2'd2) begin
              mode_next = MODE_ERROR;
            end else begin
              if (comp_index == 2'd0) begin
                held_red_next = comp_byte;
              end else begin
                held_green_next = comp_byte;
              end
              comp_index_next  = comp_index + 2'd1;
              digit_count_next = '0;
              comp_value_next  = '0;
            end
          end else begin
            mode_next = MODE_ERROR;
          end
        end
        default: mode_next = MODE_ERROR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_START;
      prefix_pos   <= '0;
      hash_nibbles <= '0;
      digit_count  <= '0;
      comp_index   <= '0;
      comp_value   <= '0;
      held_red     <= '0;
      held_green   <= '0;
    end else if (take) begin
      mode         <= mode_next;
      prefix_pos   <= prefix_pos_next;
      hash_nibbles <= hash_nibbles_next;
      digit_count  <= digit_count_next;
      comp_index   <= comp_index_next;
      comp_value   <= comp_value_next;
      held_red     <= held_red_next;
      held_green   <= held_green_next;
    end
  end

endmodule

`default_nettype wire

@@ src/csp_out_reg.sv @@
// Result register of the color spec parser: holds one result until taken.
// Uses csp_pkg for the result struct.
`default_nettype none

module csp_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 res_load,
  input  wire csp_pkg::csp_result_t res,
  output logic                      out_free,
  output logic                      color_valid,
  input  wire logic                 color_stall,
  output logic                      valid_res,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue
);

  csp_pkg::csp_result_t held;

  assign out_free  = !color_valid || !color_stall;
  assign valid_res = held.ok;
  assign red       = held.red;
  assign green     = held.green;
  assign blue      = held.blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (res_load) begin
      color_valid <= 1'b1;
    end else if (!color_stall) begin
      color_valid <= 1'b0;
    end
    if (res_load) begin
      held <= res;
    end
  end

endmodule

`default_nettype wire

@@ src/color_spec_parser.sv @@
// Color spec parser: one character per cycle, one result per terminating zero.
// A zero is held in csp_in_reg; its result then loads into the result register.
// Throughput: one character per cycle; a zero waits for a free result register.
// Reset (rst, synchronous): parser returns to start of spec, both registers empty.
// Top level; instantiates csp_in_reg, csp_step and csp_out_reg, uses csp_pkg.
`default_nettype none

module color_spec_parser #(
  parameter int MAX_HASH_DIGITS      = csp_pkg::MAX_HASH_DIGITS,
  parameter int MAX_COMPONENT_DIGITS = csp_pkg::MAX_COMPONENT_DIGITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_stall,
  input  wire logic [7:0] character,
  output logic            color_valid,
  input  wire logic       color_stall,
  output logic            valid_res,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue
);

  logic                 held_valid;
  logic [7:0]           held_char;
  logic                 take;
  logic                 res_load;
  logic                 out_free;
  csp_pkg::csp_result_t res;

  csp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .take       (take),
    .held_valid (held_valid),
    .held_char  (held_char)
  );

  csp_step #(
    .MAX_HASH_DIGITS      (MAX_HASH_DIGITS),
    .MAX_COMPONENT_DIGITS (MAX_COMPONENT_DIGITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_char  (held_char),
    .out_free   (out_free),
    .take       (take),
    .res_load   (res_load),
    .res        (res)
  );

  csp_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .res_load    (res_load),
    .res         (res),
    .out_free    (out_free),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .valid_res   (valid_res),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

endmodule

`default_nettype wire

@@ src/csp_checker.sv @@
// Port-level checks for the color spec parser, bound to the top level.
// Sees only the ports of color_spec_parser.
`default_nettype none

module csp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       char_stall,
  input wire logic       color_valid,
  input wire logic       color_stall,
  input wire logic       valid_res,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    color_valid && color_stall |=>
      color_valid && $stable({valid_res, red, green, blue}))
    else $error("result changed while stalled");

  // Failed parses report zero channels.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    color_valid && !valid_res |-> red == 8'h00 && green == 8'h00 && blue == 8'h00)
    else $error("invalid result with nonzero channel");

  // Nothing is shown right after reset.
  a_rst: assert property (@(posedge clk)
    rst |=> !color_valid)
    else $error("result present after reset");

  // Input side stalls only while a result is held back.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !color_valid || !color_stall |-> !char_stall)
    else $error("input stalled with free result register");

endmodule

bind color_spec_parser csp_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .char_stall  (char_stall),
  .color_valid (color_valid),
  .color_stall (color_stall),
  .valid_res   (valid_res),
  .red         (red),
  .green       (green),
  .blue        (blue)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for color_spec_parser: streams spec characters with random gaps and
// result stalls, predicts each color from its own parser and checks it on arrival.
// Depends on csp_pkg and color_spec_parser.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_AFTER_CHARS = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int STIM_CHARS = 900;

  typedef enum logic [2:0] {
    SCAN_START, SCAN_HASH, SCAN_PREFIX, SCAN_RGB, SCAN_ERROR
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       drain_first;
  } char_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  logic [7:0] character = 8'h00;
  logic       color_valid;
  logic       color_stall = 1'b0;
  logic       valid_res;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  color_spec_parser u_top (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .character   (character),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .valid_res   (valid_res),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  // Parser state mirrored by the predictor.
  scan_mode_e  scan_mode;
  logic [1:0]  prefix_seen;
  logic [47:0] hash_digits;
  logic [3:0]  digit_total;
  logic [1:0]  comp_sel;
  logic [15:0] comp_digits;
  logic [7:0]  red_done;
  logic [7:0]  green_done;

  char_req_t            pending_chars[$];
  csp_pkg::csp_result_t expected_colors[$];

  bit        char_taken = 1'b0;
  bit        color_taken = 1'b0;
  bit        drain_next = 1'b0;
  bit        hold_done = 1'b0;
  int        queued_total = 0;
  int        chars_accepted = 0;
  int        colors_seen = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        tx_wait = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  logic      stall_next;
  char_req_t tx_req;
  bit [31:0] cycle_count = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return {1'b1, 4'(ch - "0")};
    if (ch >= "a" && ch <= "f") return {1'b1, 4'(ch - "a" + 10)};
    if (ch >= "A" && ch <= "F") return {1'b1, 4'(ch - "A" + 10)};
    return 5'd0;
  endfunction

  // One digit is doubled into both nibbles, longer runs keep their top byte.
  function automatic logic [7:0] scale_component(input logic [15:0] digits, input int count);
    if (count <= 1) return {digits[3:0], digits[3:0]};
    return 8'(digits >> (4 * count - 8));
  endfunction

  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    case (pos)
      2'd0: return csp_pkg::CHAR_R;
      2'd1: return csp_pkg::CHAR_G;
      2'd2: return csp_pkg::CHAR_B;
      default: return csp_pkg::CHAR_COLON;
    endcase
  endfunction

  task automatic restart_scan();
    scan_mode   = SCAN_START;
    prefix_seen = 2'd0;
    hash_digits = 48'd0;
    digit_total = 4'd0;
    comp_sel    = 2'd0;
    comp_digits = 16'd0;
    red_done    = 8'd0;
    green_done  = 8'd0;
  endtask

  task automatic track_char(input logic [7:0] ch);
    logic [4:0]           hx;
    csp_pkg::csp_result_t color;
    int                   per;
    logic [47:0]          field_mask;
    hx = hex_value(ch);
    if (ch == csp_pkg::CHAR_NUL) begin
      color = '0;
      if (scan_mode == SCAN_HASH && digit_total != 0 && digit_total % 3 == 0) begin
        per        = digit_total / 3;
        field_mask = (48'd1 << (4 * per)) - 48'd1;
        color.ok    = 1'b1;
        color.red   = scale_component(16'((hash_digits >> (8 * per)) & field_mask), per);
        color.green = scale_component(16'((hash_digits >> (4 * per)) & field_mask), per);
        color.blue  = scale_component(16'(hash_digits & field_mask), per);
      end else if (scan_mode == SCAN_RGB && comp_sel == 2'd2 && digit_total != 0) begin
        color.ok    = 1'b1;
        color.red   = red_done;
        color.green = green_done;
        color.blue  = scale_component(comp_digits, digit_total);
      end
      expected_colors.push_back(color);
      restart_scan();
    end else begin
      case (scan_mode)
        SCAN_START: begin
          if (ch == csp_pkg::CHAR_HASH) begin
            scan_mode = SCAN_HASH;
          end else if (ch == csp_pkg::CHAR_R) begin
            scan_mode   = SCAN_PREFIX;
            prefix_seen = 2'd1;
          end else begin
            scan_mode = SCAN_ERROR;
          end
        end
        SCAN_HASH: begin
          if (!hx[4] || digit_total >= csp_pkg::MAX_HASH_DIGITS) begin
            scan_mode = SCAN_ERROR;
          end else begin
            hash_digits = {hash_digits[43:0], hx[3:0]};
            digit_total += 4'd1;
          end
        end
        SCAN_PREFIX: begin
          if (ch != prefix_char(prefix_seen)) begin
            scan_mode = SCAN_ERROR;
          end else if (prefix_seen == 2'd3) begin
            scan_mode   = SCAN_RGB;
            prefix_seen = 2'd0;
          end else begin
            prefix_seen += 2'd1;
          end
        end
        SCAN_RGB: begin
          if (hx[4]) begin
            if (digit_total >= csp_pkg::MAX_COMPONENT_DIGITS) begin
              scan_mode = SCAN_ERROR;
            end else begin
              comp_digits = {comp_digits[11:0], hx[3:0]};
              digit_total += 4'd1;
            end
          end else if (ch == csp_pkg::CHAR_SLASH && digit_total != 0 && comp_sel < 2'd2) begin
            if (comp_sel == 2'd0) red_done = scale_component(comp_digits, digit_total);
            else green_done = scale_component(comp_digits, digit_total);
            comp_sel    += 2'd1;
            digit_total = 4'd0;
            comp_digits = 16'd0;
          end else begin
            scan_mode = SCAN_ERROR;
          end
        end
        default: scan_mode = SCAN_ERROR;
      endcase
    end
  endtask

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(0, 1) == 0) return 8'("a" + v - 10);
    return 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic add_char(input logic [7:0] ch);
    pending_chars.push_back('{ch: ch, drain_first: drain_next});
    drain_next = 1'b0;
    queued_total++;
  endtask

  task automatic add_hex_run(input int count);
    repeat (count) add_char(random_hex_char());
  endtask

  // Emit the rgb prefix; a position of 4 or more leaves it intact.
  task automatic add_prefix(input int bad_at);
    for (int k = 0; k < 4; k++) add_char(k == bad_at ? random_byte() : prefix_char(2'(k)));
  endtask

  task automatic add_components(input int comps, input int min_len, input int max_len);
    for (int k = 0; k < comps; k++) begin
      if (k > 0) add_char(csp_pkg::CHAR_SLASH);
      add_hex_run($urandom_range(min_len, max_len));
    end
  endtask

  task automatic add_spec(input string s);
    for (int k = 0; k < s.len(); k++) add_char(s[k]);
    add_char(csp_pkg::CHAR_NUL);
  endtask

  task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: color %0d %s mismatch, expected %h, actual %h",
               $time, colors_seen, label, want, got);
      mismatches++;
    end
  endtask

  // Sample both channels, predict and check.
  always @(posedge clk) begin
    csp_pkg::csp_result_t want;
    cycle_count++;
    char_taken  = !rst && char_valid && !char_stall;
    color_taken = !rst && color_valid && !color_stall;
    if (color_taken) begin
      if (expected_colors.size() == 0) begin
        $display("%0t ns: unexpected color, expected none, actual ok=%b rgb=%h%h%h",
                 $time, valid_res, red, green, blue);
        mismatches++;
      end else begin
        want = expected_colors.pop_front();
        check_field("valid_res", 8'(want.ok), 8'(valid_res));
        check_field("red", want.red, red);
        check_field("green", want.green, green);
        check_field("blue", want.blue, blue);
      end
      colors_seen++;
    end
    if (char_taken) begin
      track_char(character);
      chars_accepted++;
    end
    if (char_taken || color_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Character driver: advance on accept, hold while stalled.
  always @(negedge clk) begin
    if (!rst && (!char_valid || char_taken)) begin
      if (tx_wait > 0) begin
        tx_wait--;
        char_valid <= 1'b0;
      end else if (pending_chars.size() != 0 &&
                   !(pending_chars[0].drain_first && expected_colors.size() != 0)) begin
        tx_req = pending_chars.pop_front();
        character  <= tx_req.ch;
        char_valid <= 1'b1;
        tx_wait = (cycle_count[9:8] == 2'b01) ? 0 : pick_idle();
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off to back up the block.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (!hold_done && chars_accepted >= HOLD_AFTER_CHARS) begin
      hold_done  = 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      stall_next = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else begin
      stall_next = 1'b0;
      if (cycle_count[9:8] != 2'b10) stall_left = pick_idle();
    end
    color_stall <= rst ? 1'b0 : stall_next;
  end

  initial begin
    int roll;
    int count;
    int cut;
    bit mid_drain_done;
    mid_drain_done = 1'b0;
    restart_scan();

    add_spec("");
    add_spec("x");
    add_spec("#fA9");
    add_spec("#00ffFF");
    add_spec("#0123456789aB");
    add_spec("#cdeCDE789abcd");
    add_spec("#12");
    add_spec("#");
    add_spec("#12g");
    add_spec("rgb:f/0/A");
    add_spec("rgb:FFFF/0000/1234");
    add_spec("rgb:12345/0/0");
    add_spec("rgb://1");
    add_spec("rgb:1/2/3/4");
    add_spec("rgb:1/2");
    add_spec("rGb:1/2/3");
    add_spec("rgb:1/2/3x");
    add_spec("#fff/");
    add_char(8'hff);
    add_char(8'h80);
    add_char(csp_pkg::CHAR_NUL);

    // Let the directed part drain before the random traffic starts.
    drain_next = 1'b1;
    while (queued_total < STIM_CHARS) begin
      if (!mid_drain_done && queued_total > STIM_CHARS / 2) begin
        drain_next     = 1'b1;
        mid_drain_done = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        add_char(csp_pkg::CHAR_HASH);
        add_hex_run(3 * $urandom_range(1, 4));
      end else if (roll < 70) begin
        add_prefix(4);
        add_components(3, 1, csp_pkg::MAX_COMPONENT_DIGITS);
      end else if (roll < 78) begin
        add_char(csp_pkg::CHAR_HASH);
        count = $urandom_range(0, csp_pkg::MAX_HASH_DIGITS + 2);
        cut   = $urandom_range(0, count);
        add_hex_run(cut);
        if ($urandom_range(0, 2) == 0) add_char(random_byte());
        add_hex_run(count - cut);
      end else if (roll < 86) begin
        add_prefix($urandom_range(0, 7));
        add_components($urandom_range(0, 4), 0, csp_pkg::MAX_COMPONENT_DIGITS + 1);
        if ($urandom_range(0, 3) == 0) add_char(random_byte());
      end else if (roll < 94) begin
        add_prefix(4);
        add_components(3, 1, csp_pkg::MAX_COMPONENT_DIGITS);
        add_char(random_byte());
      end else begin
        repeat ($urandom_range(1, 6)) add_char(random_byte());
      end
      add_char(csp_pkg::CHAR_NUL);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || char_valid) @(negedge clk);
    while (expected_colors.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
